// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

  // command codes carried in tuser
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_RESTART = 3'd2;
  localparam logic [2:0] CMD_WRITE   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_STOP    = 3'd5;

  // bus phase codes
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_RS_LOW  = 4'd1;
  localparam logic [3:0] PH_RS_HIGH = 4'd2;
  localparam logic [3:0] PH_ST_HOLD = 4'd3;
  localparam logic [3:0] PH_BIT_LOW = 4'd4;
  localparam logic [3:0] PH_BIT_HI  = 4'd5;
  localparam logic [3:0] PH_ACK_LOW = 4'd6;
  localparam logic [3:0] PH_ACK_HI  = 4'd7;
  localparam logic [3:0] PH_SP_LOW  = 4'd8;
  localparam logic [3:0] PH_SP_HIGH = 4'd9;
  localparam logic [3:0] PH_SP_REL  = 4'd10;

  localparam int unsigned HP_W       = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;
  localparam logic [HP_W-1:0] HP_RESET = 16'd50;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // one classified tick, as it waits in the queue
  typedef struct packed {
    logic       is_cmd;
    logic       is_read;
    logic [3:0] phase0;
    logic [7:0] shift_init;
    logic       nack;
    logic       sda;
  } entry_t;

endpackage

// ===== rtl/core/i2cm_fifo.sv =====
module i2cm_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_ready && rd_valid;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/i2cm_front.sv =====
module i2cm_front (
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [i2cm_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [i2cm_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              q_valid,
  input  logic                              q_ready,
  output i2cm_pkg::entry_t                  q_entry
);

  logic [7:0] tx;

  assign tx       = s_tdata[7:0];
  assign q_valid  = s_tvalid;
  assign s_tready = q_ready;

  // decode the command into its opening phase
  always_comb begin
    q_entry            = '0;
    q_entry.nack       = s_tdata[8];
    q_entry.sda        = s_tdata[9];
    q_entry.shift_init = tx;
    q_entry.phase0     = i2cm_pkg::PH_IDLE;
    unique case (s_tuser)
      i2cm_pkg::CMD_START: begin
        q_entry.is_cmd = 1'b1;
        q_entry.phase0 = i2cm_pkg::PH_ST_HOLD;
      end
      i2cm_pkg::CMD_RESTART: begin
        q_entry.is_cmd = 1'b1;
        q_entry.phase0 = i2cm_pkg::PH_RS_LOW;
      end
      i2cm_pkg::CMD_WRITE: begin
        q_entry.is_cmd = 1'b1;
        q_entry.phase0 = i2cm_pkg::PH_BIT_LOW;
      end
      i2cm_pkg::CMD_READ: begin
        q_entry.is_cmd     = 1'b1;
        q_entry.is_read    = 1'b1;
        q_entry.shift_init = 8'h00;
        q_entry.phase0     = i2cm_pkg::PH_BIT_LOW;
      end
      i2cm_pkg::CMD_STOP: begin
        q_entry.is_cmd = 1'b1;
        q_entry.phase0 = i2cm_pkg::PH_SP_LOW;
      end
      default: begin
        q_entry.is_cmd = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/i2cm_back.sv =====
module i2cm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [i2cm_pkg::HP_W-1:0]         cfg_wr_data,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  i2cm_pkg::entry_t                  q_entry,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0]   m_tdata
);

  logic [i2cm_pkg::HP_W-1:0] half_period;
  logic [i2cm_pkg::HP_W-1:0] hp_eff;
  logic [3:0]  phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [i2cm_pkg::HP_W-1:0] tick_count, tick_count_next;
  logic        cur_read, cur_read_next;
  logic        nack_flag, nack_flag_next;
  logic        ack_reg, ack_reg_next;
  logic [7:0]  rx_reg, rx_reg_next;
  logic        scl_out, scl_out_next;
  logic        sda_out, sda_out_next;
  logic        scl, sda, done, rejected;
  logic        step;
  logic        out_valid;
  logic [i2cm_pkg::OUT_DATA_W-1:0] out_data;

  assign q_ready  = !out_valid || m_tready;
  assign step     = q_valid && q_ready;
  assign hp_eff   = (half_period == '0) ? i2cm_pkg::HP_W'(1) : half_period;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    tick_count_next = tick_count;
    cur_read_next   = cur_read;
    nack_flag_next  = nack_flag;
    ack_reg_next    = ack_reg;
    rx_reg_next     = rx_reg;
    scl_out_next    = scl_out;
    sda_out_next    = sda_out;
    rejected        = 1'b0;
    done            = 1'b0;

    // command launch or rejection
    if (q_entry.is_cmd) begin
      if (phase != i2cm_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        cur_read_next   = q_entry.is_read;
        tick_count_next = '0;
        bit_count_next  = '0;
        nack_flag_next  = q_entry.nack;
        shift_reg_next  = q_entry.shift_init;
        phase_next      = q_entry.phase0;
      end
    end

    // line levels of the phase in force this tick
    unique case (phase_next)
      i2cm_pkg::PH_RS_LOW:  begin scl = 1'b0; sda = 1'b1; end
      i2cm_pkg::PH_RS_HIGH: begin scl = 1'b1; sda = 1'b1; end
      i2cm_pkg::PH_ST_HOLD: begin scl = 1'b1; sda = 1'b0; end
      i2cm_pkg::PH_BIT_LOW: begin scl = 1'b0; sda = cur_read_next | shift_reg_next[7]; end
      i2cm_pkg::PH_BIT_HI:  begin scl = 1'b1; sda = cur_read_next | shift_reg_next[7]; end
      i2cm_pkg::PH_ACK_LOW: begin scl = 1'b0; sda = !cur_read_next | nack_flag_next; end
      i2cm_pkg::PH_ACK_HI:  begin scl = 1'b1; sda = !cur_read_next | nack_flag_next; end
      i2cm_pkg::PH_SP_LOW:  begin scl = 1'b0; sda = 1'b0; end
      i2cm_pkg::PH_SP_HIGH: begin scl = 1'b1; sda = 1'b0; end
      i2cm_pkg::PH_SP_REL:  begin scl = 1'b1; sda = 1'b1; end
      default:              begin scl = scl_out; sda = sda_out; end
    endcase

    // half-period pacing and phase advance
    if (phase_next != i2cm_pkg::PH_IDLE) begin
      if (({1'b0, tick_count_next} + 17'd1) >= {1'b0, hp_eff}) begin
        tick_count_next = '0;
        unique case (phase_next)
          i2cm_pkg::PH_RS_LOW:  phase_next = i2cm_pkg::PH_RS_HIGH;
          i2cm_pkg::PH_RS_HIGH: phase_next = i2cm_pkg::PH_ST_HOLD;
          i2cm_pkg::PH_ST_HOLD: begin
            phase_next     = i2cm_pkg::PH_BIT_LOW;
            bit_count_next = '0;
          end
          i2cm_pkg::PH_BIT_LOW: phase_next = i2cm_pkg::PH_BIT_HI;
          i2cm_pkg::PH_BIT_HI: begin
            shift_reg_next = {shift_reg_next[6:0], cur_read_next & q_entry.sda};
            bit_count_next = bit_count_next + 4'd1;
            phase_next     = (bit_count_next >= i2cm_pkg::BITS_PER_BYTE) ?
                             i2cm_pkg::PH_ACK_LOW : i2cm_pkg::PH_BIT_LOW;
          end
          i2cm_pkg::PH_ACK_LOW: phase_next = i2cm_pkg::PH_ACK_HI;
          i2cm_pkg::PH_ACK_HI: begin
            if (cur_read_next) begin
              rx_reg_next = shift_reg_next;
            end else begin
              ack_reg_next = !q_entry.sda;
            end
            phase_next   = i2cm_pkg::PH_IDLE;
            scl_out_next = 1'b0;
            sda_out_next = 1'b0;
            done         = 1'b1;
          end
          i2cm_pkg::PH_SP_LOW:  phase_next = i2cm_pkg::PH_SP_HIGH;
          i2cm_pkg::PH_SP_HIGH: phase_next = i2cm_pkg::PH_SP_REL;
          i2cm_pkg::PH_SP_REL: begin
            phase_next   = i2cm_pkg::PH_IDLE;
            scl_out_next = 1'b1;
            sda_out_next = 1'b1;
            done         = 1'b1;
          end
          default: phase_next = i2cm_pkg::PH_IDLE;
        endcase
      end else begin
        tick_count_next = tick_count_next + i2cm_pkg::HP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HP_RESET;
    end else if (cfg_wr_en) begin
      half_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cm_pkg::PH_IDLE;
      bit_count  <= '0;
      shift_reg  <= '0;
      tick_count <= '0;
      cur_read   <= 1'b0;
      nack_flag  <= 1'b0;
      ack_reg    <= 1'b0;
      rx_reg     <= '0;
      scl_out    <= 1'b1;
      sda_out    <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (step) begin
        phase      <= phase_next;
        bit_count  <= bit_count_next;
        shift_reg  <= shift_reg_next;
        tick_count <= tick_count_next;
        cur_read   <= cur_read_next;
        nack_flag  <= nack_flag_next;
        ack_reg    <= ack_reg_next;
        rx_reg     <= rx_reg_next;
        scl_out    <= scl_out_next;
        sda_out    <= sda_out_next;
        out_valid  <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, fields from bit 0: scl, sda, busy, done, rx_byte, acked, rejected
  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= {2'b00, rejected, ack_reg_next, rx_reg_next, done,
                   (phase_next != i2cm_pkg::PH_IDLE), sda, scl};
    end
  end

endmodule

// ===== rtl/core/i2c_master_byte_engine_top.sv =====
// channel   dir  tdata (lsb first)                                   tuser
// s_axis    in   tx_byte[7:0] send_nack[8] sda_in[9] zero[15:10]    cmd[2:0]
// m_axis    out  scl_level[0] sda_level[1] busy_res[2] done_res[3]  -
//                rx_byte[11:4] acked[12] cmd_rejected[13] zero[15:14]
// cfg       in   half_period_ticks[15:0] written on cfg_wr_en        -
//
// one item per cycle sustained while m_axis_tready is high: each item is one bus tick, computed
// combinationally by the back engine (state update, 16-bit half-period compare, phase step)
// an accepted input is held in the tick queue and then in the result register
// rst is synchronous, active high; it empties the queue and returns the bus engine
// to idle with both lines released and the half period at 50 ticks
// a stalled m_axis fills the result register and then the tick queue, after which
// s_axis_tready drops; the input side never blocks the output side
module i2c_master_byte_engine_top #(
  parameter int unsigned QUEUE_DEPTH = 2  // tick queue entries, 2 or more
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [i2cm_pkg::HP_W-1:0]         cfg_wr_data,    // half_period_ticks
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [i2cm_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // tx_byte, send_nack, sda_in
  input  logic [i2cm_pkg::IN_USER_W-1:0]    s_axis_tuser,   // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // scl, sda, busy, done, rx, ack, rej
);

  i2cm_pkg::entry_t front_entry;
  i2cm_pkg::entry_t back_entry;
  logic             front_valid;
  logic             front_ready;
  logic             back_valid;
  logic             back_ready;

  // front: decode the command and classify the tick
  i2cm_front u_front (
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .q_valid  (front_valid),
    .q_ready  (front_ready),
    .q_entry  (front_entry)
  );

  // short queue so either side can stall on its own
  i2cm_fifo #(
    .WIDTH ($bits(i2cm_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_entry),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_entry)
  );

  // back: bus timing engine plus result register
  i2cm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (back_valid),
    .q_ready     (back_ready),
    .q_entry     (back_entry),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata)
  );

endmodule

// ===== rtl/core/i2cm_checker.sv =====
module i2cm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [i2cm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic scl_o, sda_o, busy_o, done_o;

  assign scl_o  = m_axis_tdata[0];
  assign sda_o  = m_axis_tdata[1];
  assign busy_o = m_axis_tdata[2];
  assign done_o = m_axis_tdata[3];

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // completion leaves the engine idle, with scl high on the final tick
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && done_o |-> !busy_o && scl_o)
    else $error("done with busy or scl low");

  // a resting bus has both lines low or both released
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !busy_o && !done_o |-> scl_o == sda_o)
    else $error("idle bus with split line levels");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
